FILE: design/owvs_pkg.sv
package owvs_pkg;

  // Field widths
  localparam int SPEED_W = 16;
  localparam int ANGLE_W = 16;

  // Phase and Q30 sine formats
  localparam int PHASE_W = 32;
  localparam int FRAC_W  = 30;
  localparam int UNIT_W  = FRAC_W + 1;
  localparam int PROD_W  = 2 * UNIT_W;

  // Pipeline shape
  localparam int NUM_WHEELS   = 4;
  localparam int HORNER_STEPS = 6;
  localparam int SINE_STAGES  = HORNER_STEPS + 2;
  localparam int SCALE_STAGES = 2;
  localparam int PIPE_STAGES  = 1 + SINE_STAGES + SCALE_STAGES;

  // Wheel mounting angles as 32-bit binary phases
  localparam logic [PHASE_W-1:0] PHASE_SIXTY     = 32'h2AAA_AAAB;
  localparam logic [PHASE_W-1:0] PHASE_FORTYFIVE = 32'h2000_0000;

  localparam logic [UNIT_W-1:0] Q_ONE  = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [PROD_W-1:0] Q_HALF = PROD_W'(1) << (FRAC_W - 1);

  // Odd Taylor coefficients of sin(pi/2 * x) in Q30, highest order first
  localparam logic [UNIT_W-1:0] COEF_TOP = 31'd61;
  typedef logic [UNIT_W-1:0] coef_arr_t [HORNER_STEPS];
  localparam coef_arr_t HORNER_COEF = '{
    31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
  };

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic [ANGLE_W-1:0]        heading;
  } req_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] drive_first;
    logic signed [SPEED_W-1:0] drive_second;
    logic signed [SPEED_W-1:0] drive_third;
    logic signed [SPEED_W-1:0] drive_fourth;
  } res_t;

  typedef struct packed {
    logic              neg;
    logic [UNIT_W-1:0] x;
  } fold_t;

endpackage

FILE: design/owvs_sine_lane.sv
module owvs_sine_lane (
  input  logic                                  clk_i,
  input  logic [owvs_pkg::SINE_STAGES-1:0]      en_i,
  input  logic [owvs_pkg::UNIT_W-1:0]           x_i,
  input  logic                                  neg_i,
  output logic [owvs_pkg::UNIT_W-1:0]           s_o,
  output logic                                  neg_o
);

  localparam int Last = owvs_pkg::SINE_STAGES - 1;

  logic [owvs_pkg::UNIT_W-1:0] x_q  [owvs_pkg::SINE_STAGES-1];
  logic [owvs_pkg::UNIT_W-1:0] x2_q [owvs_pkg::HORNER_STEPS];
  logic [owvs_pkg::UNIT_W-1:0] p_q  [1:owvs_pkg::HORNER_STEPS];
  logic                        n_q  [owvs_pkg::SINE_STAGES];
  logic [owvs_pkg::UNIT_W-1:0] s_q;

  // Square the folded angle, rounded to Q30
  logic [owvs_pkg::PROD_W-1:0] sq_rnd;
  assign sq_rnd = owvs_pkg::PROD_W'(x_i) * owvs_pkg::PROD_W'(x_i) + owvs_pkg::Q_HALF;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x2_q[0] <= sq_rnd[owvs_pkg::FRAC_W +: owvs_pkg::UNIT_W];
      x_q[0]  <= x_i;
      n_q[0]  <= neg_i;
    end
  end

  // One Horner step per stage: p = c - round(p * x^2)
  for (genvar j = 1; j <= owvs_pkg::HORNER_STEPS; j++) begin : g_horner
    logic [owvs_pkg::UNIT_W-1:0] p_in;
    logic [owvs_pkg::PROD_W-1:0] rnd;

    if (j == 1) begin : g_first
      assign p_in = owvs_pkg::COEF_TOP;
    end else begin : g_next
      assign p_in = p_q[j-1];
    end

    assign rnd = owvs_pkg::PROD_W'(p_in) * owvs_pkg::PROD_W'(x2_q[j-1]) + owvs_pkg::Q_HALF;

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        p_q[j] <= owvs_pkg::HORNER_COEF[j-1] - rnd[owvs_pkg::FRAC_W +: owvs_pkg::UNIT_W];
        x_q[j] <= x_q[j-1];
        n_q[j] <= n_q[j-1];
      end
    end

    if (j < owvs_pkg::HORNER_STEPS) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          x2_q[j] <= x2_q[j-1];
        end
      end
    end
  end

  // Multiply by x and clamp to one
  logic [owvs_pkg::PROD_W-1:0] px_rnd;
  logic [owvs_pkg::PROD_W-owvs_pkg::FRAC_W-1:0] px;
  assign px_rnd = owvs_pkg::PROD_W'(p_q[owvs_pkg::HORNER_STEPS])
                * owvs_pkg::PROD_W'(x_q[Last-1]) + owvs_pkg::Q_HALF;
  assign px     = px_rnd[owvs_pkg::PROD_W-1:owvs_pkg::FRAC_W];

  always_ff @(posedge clk_i) begin
    if (en_i[Last]) begin
      s_q       <= (px > {1'b0, owvs_pkg::Q_ONE}) ? owvs_pkg::Q_ONE
                                                  : px[owvs_pkg::UNIT_W-1:0];
      n_q[Last] <= n_q[Last-1];
    end
  end

  assign s_o   = s_q;
  assign neg_o = n_q[Last];

endmodule

FILE: design/owvs_scale.sv
module owvs_scale (
  input  logic                                   clk_i,
  input  logic [owvs_pkg::SCALE_STAGES-1:0]      en_i,
  input  logic [owvs_pkg::SPEED_W-1:0]           mag_i,
  input  logic                                   vneg_i,
  input  logic [owvs_pkg::UNIT_W-1:0]            s_i,
  input  logic                                   sneg_i,
  output logic signed [owvs_pkg::SPEED_W-1:0]    drive_o
);

  localparam int MulW = owvs_pkg::SPEED_W + owvs_pkg::UNIT_W;
  localparam int MagW = owvs_pkg::SPEED_W + 1;
  localparam logic [MulW-1:0] Half = MulW'(1) << (owvs_pkg::FRAC_W - 1);
  localparam logic [MagW-1:0] Lim  = MagW'(1) << (owvs_pkg::SPEED_W - 1);

  logic [MulW-1:0] mul_rnd;
  logic [MagW-1:0] prod_q;
  logic            neg_q;
  logic [MagW-1:0] sat;
  logic signed [owvs_pkg::SPEED_W-1:0] drive_q;

  // Scale speed magnitude by the sine, rounded half away from zero
  assign mul_rnd = MulW'(mag_i) * MulW'(s_i) + Half;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= mul_rnd[MulW-1:owvs_pkg::FRAC_W];
      neg_q  <= vneg_i ^ sneg_i;
    end
  end

  // Saturate to the signed range and apply the sign
  always_comb begin
    if (neg_q) begin
      sat = (prod_q > Lim) ? Lim : prod_q;
    end else begin
      sat = (prod_q > Lim - 1'b1) ? Lim - 1'b1 : prod_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      drive_q <= neg_q ? -$signed(sat[owvs_pkg::SPEED_W-1:0])
                       : $signed(sat[owvs_pkg::SPEED_W-1:0]);
    end
  end

  assign drive_o = drive_q;

endmodule

FILE: design/omni_wheel_velocity_split.sv
// Pipeline: the entry stage that accepts a request, then 10 register stages, the last one
// being the output register that holds its result.
// Throughput: one request per cycle when out_stall_i is low; no stage reuses a multiplier.
// A one-entry input skid holds a request while the full pipeline waits on a stalled output.
// Reset: rst_ni is asynchronous, active low; it clears the stage valid bits and the skid.
module omni_wheel_velocity_split (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  owvs_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output owvs_pkg::res_t   out_data_o
);

  localparam int Stages    = owvs_pkg::PIPE_STAGES;
  localparam int MagStages = 1 + owvs_pkg::SINE_STAGES;
  localparam int Wheels    = owvs_pkg::NUM_WHEELS;

  // Fold a phase into the first quadrant and keep the sign of its sine
  function automatic owvs_pkg::fold_t fold_phase(input logic [owvs_pkg::PHASE_W-1:0] phase);
    logic [owvs_pkg::UNIT_W-1:0] frac;
    owvs_pkg::fold_t             r;
    frac  = {1'b0, phase[owvs_pkg::FRAC_W-1:0]};
    r.x   = phase[owvs_pkg::FRAC_W] ? (owvs_pkg::Q_ONE - frac) : frac;
    r.neg = phase[owvs_pkg::PHASE_W-1];
    return r;
  endfunction

  logic            skid_full_q, skid_full_d;
  owvs_pkg::req_t  skid_q;
  logic            feed_valid;
  owvs_pkg::req_t  feed;
  logic [Stages-1:0] v_q, v_d, adv;

  // Pick the skid entry ahead of a new request
  assign feed_valid = skid_full_q | in_valid_i;
  assign feed       = skid_full_q ? skid_q : in_data_i;
  assign in_stall_o = skid_full_q;

  // Advance a stage when it is empty or the stage after it advances
  always_comb begin
    adv[Stages-1] = !v_q[Stages-1] || !out_stall_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_comb begin
    v_d[0] = adv[0] ? feed_valid : v_q[0];
    for (int k = 1; k < Stages; k++) begin
      v_d[k] = adv[k] ? v_q[k-1] : v_q[k];
    end
    if (skid_full_q) begin
      skid_full_d = !adv[0];
    end else begin
      skid_full_d = in_valid_i && !adv[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      skid_full_q <= 1'b0;
    end else begin
      v_q         <= v_d;
      skid_full_q <= skid_full_d;
    end
  end

  // Entry stage: wheel phases, quadrant fold, speed magnitude
  logic [owvs_pkg::PHASE_W-1:0] ph;
  logic [owvs_pkg::PHASE_W-1:0] phase [Wheels];
  owvs_pkg::fold_t              fold  [Wheels];
  logic [owvs_pkg::SPEED_W-1:0] speed_u, mag;
  logic                         vneg;

  always_comb begin
    ph       = {feed.heading, {(owvs_pkg::PHASE_W - owvs_pkg::ANGLE_W){1'b0}}};
    phase[0] = owvs_pkg::PHASE_SIXTY - ph;
    phase[1] = owvs_pkg::PHASE_FORTYFIVE + ph;
    phase[2] = ph - owvs_pkg::PHASE_FORTYFIVE;
    phase[3] = '0 - owvs_pkg::PHASE_SIXTY - ph;
    for (int w = 0; w < Wheels; w++) begin
      fold[w] = fold_phase(phase[w]);
    end
    speed_u = feed.speed;
    vneg    = speed_u[owvs_pkg::SPEED_W-1];
    mag     = vneg ? (~speed_u + 1'b1) : speed_u;
  end

  logic [owvs_pkg::UNIT_W-1:0]  x0_q    [Wheels];
  logic                         n0_q    [Wheels];
  logic [owvs_pkg::SPEED_W-1:0] mag_q   [MagStages];
  logic                         vneg_q  [MagStages];

  // Load the entry stage, carry the speed along, hold the skid
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int w = 0; w < Wheels; w++) begin
        x0_q[w] <= fold[w].x;
        n0_q[w] <= fold[w].neg;
      end
      mag_q[0]  <= mag;
      vneg_q[0] <= vneg;
    end
    for (int k = 1; k < MagStages; k++) begin
      if (adv[k]) begin
        mag_q[k]  <= mag_q[k-1];
        vneg_q[k] <= vneg_q[k-1];
      end
    end
    if (!skid_full_q) begin
      skid_q <= in_data_i;
    end
  end

  // One sine pipeline and one scaler per wheel
  logic [owvs_pkg::UNIT_W-1:0]        s_w    [Wheels];
  logic                               sneg_w [Wheels];
  logic signed [owvs_pkg::SPEED_W-1:0] drive [Wheels];

  for (genvar w = 0; w < Wheels; w++) begin : g_wheel
    owvs_sine_lane u_sine (
      .clk_i (clk_i),
      .en_i  (adv[owvs_pkg::SINE_STAGES:1]),
      .x_i   (x0_q[w]),
      .neg_i (n0_q[w]),
      .s_o   (s_w[w]),
      .neg_o (sneg_w[w])
    );

    owvs_scale u_scale (
      .clk_i   (clk_i),
      .en_i    (adv[Stages-1 -: owvs_pkg::SCALE_STAGES]),
      .mag_i   (mag_q[MagStages-1]),
      .vneg_i  (vneg_q[MagStages-1]),
      .s_i     (s_w[w]),
      .sneg_i  (sneg_w[w]),
      .drive_o (drive[w])
    );
  end

  assign out_valid_o             = v_q[Stages-1];
  assign out_data_o.drive_first  = drive[0];
  assign out_data_o.drive_second = drive[1];
  assign out_data_o.drive_third  = drive[2];
  assign out_data_o.drive_fourth = drive[3];

endmodule

FILE: design/owvs_checker.sv
module owvs_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input owvs_pkg::req_t in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input owvs_pkg::res_t out_data_o
);

  // A stalled request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled request changed or dropped");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Input stall rises only when a request arrives against a stalled full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && out_valid_o && out_stall_i))
    else $error("input stall rose without a blocked request");

  // A held request implies a result is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while no result is offered");

  // Input stall drops once the output drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after the output moved");

endmodule

bind omni_wheel_velocity_split owvs_checker u_owvs_checker (.*);
